>>> rtl/prswr_pkg.sv
// Package: shared types and constants of the pulse ratio single wire receiver.
`timescale 1ns / 1ps

package prswr_pkg;

	localparam int MAX_FRAME_BYTES = 10;
	localparam int COUNTER_BITS = 17;

	localparam int CFG_DATA_W = 16;
	localparam int BYTE_COUNT_W = 4;
	localparam int BYTE_W = 8;
	localparam int BIT_POS_W = 3;

	localparam logic [CFG_DATA_W-1:0] SYNC_TIMEOUT_RESET = 16'd60000;
	localparam logic [CFG_DATA_W-1:0] INITIAL_FRAGMENT_RESET = 16'd30000;

	typedef enum logic {
		CFG_SYNC_TIMEOUT = 1'b0,
		CFG_INITIAL_FRAGMENT = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		EV_DATA = 2'd0,
		EV_FRAME_END = 2'd1,
		EV_SYNC_ERROR = 2'd2
	} event_kind_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SYNC = 2'd1,
		PH_HIGH = 2'd2,
		PH_LOW = 2'd3
	} phase_t;

endpackage

>>> rtl/pulse_ratio_single_wire_receiver.sv
// Top level: pulse ratio single wire receiver with registered result output.
//
// One line sample enters per request on the in channel (in_valid, in_ready,
// line_level). A falling edge while idle opens a frame; each following
// high phase plus low phase is one bit, set when the high time is at least
// half of the fragment. Eight bits, most significant first, make a byte.
// Results leave on the out channel (out_valid, out_ready, event_kind,
// byte_value, byte_count): a data byte, a frame end with the byte count, or
// a sync timeout error. A sample gives at most one result.
// Throughput is one request per cycle while in_ready is high; a result is valid
// in the cycle after the request that causes it is accepted, from the output register.
// While a result waits in that register, a new request is still taken if
// out_ready is high in the same cycle; otherwise in_ready drops until the
// result has been taken.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and holds the sync timeout and the initial fragment length.
// Reset returns the receiver to idle with the line taken as high and loads
// the default register values; no result is pending after reset.
`timescale 1ns / 1ps

module pulse_ratio_single_wire_receiver #(
	parameter int MaxFrameBytes = prswr_pkg::MAX_FRAME_BYTES,
	parameter int CounterBits = prswr_pkg::COUNTER_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              line_level,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        event_kind,
	output logic [prswr_pkg::BYTE_W-1:0]      byte_value,
	output logic [prswr_pkg::BYTE_COUNT_W-1:0] byte_count,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [prswr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import prswr_pkg::*;

	localparam int CmpW = (CounterBits > CFG_DATA_W) ? CounterBits : CFG_DATA_W;
	localparam logic [CounterBits-1:0] CntMax = {CounterBits{1'b1}};
	localparam logic [7:0] MaxBytes = 8'(MaxFrameBytes);

	logic [CFG_DATA_W-1:0] sync_timeout_q;
	logic [CFG_DATA_W-1:0] initial_fragment_q;

	phase_t phase_q, phase_d;
	logic prev_level_q;
	logic [CounterBits-1:0] tick_q, tick_d;
	logic [CounterBits-1:0] high_q, high_d;
	logic [CounterBits-1:0] last_q, last_d;
	logic [BIT_POS_W-1:0] bit_pos_q, bit_pos_d;
	logic [BYTE_W-1:0] shift_q, shift_d;
	logic [BYTE_COUNT_W-1:0] bytes_q, bytes_d;

	logic out_valid_q;
	event_kind_t kind_q;
	logic [BYTE_W-1:0] value_q;
	logic [BYTE_COUNT_W-1:0] count_q;

	logic in_accept;
	logic falling;
	logic [CounterBits:0] limit_sum;
	logic [CounterBits-1:0] limit;
	logic limit_zero;
	logic [CounterBits-1:0] tick_inc;
	logic tick_over_limit;
	logic sync_over;
	logic [CounterBits:0] dur_sum;
	logic [CounterBits-1:0] dur;
	logic data_bit;
	logic [BYTE_W-1:0] shift_bit;
	logic frame_full;
	logic [CounterBits-1:0] init_sat;

	logic res_emit;
	event_kind_t res_kind;
	logic [BYTE_W-1:0] res_value;
	logic [BYTE_COUNT_W-1:0] res_count;

	assign cfg_ready = 1'b1;
	assign in_ready = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;

	assign falling = prev_level_q && !line_level;
	assign limit_sum = {1'b0, last_q} + {1'b0, last_q};
	assign limit = limit_sum[CounterBits] ? CntMax : limit_sum[CounterBits-1:0];
	assign limit_zero = (limit == '0);
	assign tick_inc = (tick_q == CntMax) ? CntMax : tick_q + 1'b1;
	assign tick_over_limit = (tick_inc > limit);
	assign sync_over = (CmpW'(tick_inc) > CmpW'(sync_timeout_q));
	assign dur_sum = {1'b0, high_q} + {1'b0, tick_q};
	assign dur = dur_sum[CounterBits] ? CntMax : dur_sum[CounterBits-1:0];
	assign data_bit = (high_q >= (dur >> 1));
	assign shift_bit = shift_q | (BYTE_W'(data_bit) << bit_pos_q);
	assign frame_full = ({4'b0, bytes_q} >= MaxBytes) || (bytes_q == {BYTE_COUNT_W{1'b1}});
	assign init_sat = (CmpW'(initial_fragment_q) > CmpW'(CntMax)) ?
		CntMax : CounterBits'(initial_fragment_q);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (falling) phase_d = PH_SYNC;
			end
			PH_SYNC: begin
				if (!line_level) begin
					if (sync_over) phase_d = PH_IDLE;
				end else begin
					phase_d = limit_zero ? PH_IDLE : PH_HIGH;
				end
			end
			PH_HIGH: begin
				if (frame_full) phase_d = PH_IDLE;
				else if (line_level) begin
					if (tick_over_limit) phase_d = PH_IDLE;
				end else begin
					phase_d = limit_zero ? PH_IDLE : PH_LOW;
				end
			end
			PH_LOW: begin
				if (!line_level) begin
					if (tick_over_limit) phase_d = PH_IDLE;
				end else if (bit_pos_q != '0 && dur == '0) begin
					phase_d = PH_IDLE;
				end else begin
					phase_d = PH_HIGH;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// Result of the current sample.
	always_comb begin
		res_emit = 1'b0;
		res_kind = EV_FRAME_END;
		res_value = '0;
		res_count = bytes_q;
		unique case (phase_q)
			PH_IDLE: res_emit = 1'b0;
			PH_SYNC: begin
				if (!line_level) begin
					res_emit = sync_over;
					res_kind = EV_SYNC_ERROR;
					res_count = '0;
				end else begin
					res_emit = limit_zero;
				end
			end
			PH_HIGH: begin
				if (frame_full) res_emit = 1'b1;
				else if (line_level) res_emit = tick_over_limit;
				else res_emit = limit_zero;
			end
			PH_LOW: begin
				if (!line_level) begin
					res_emit = tick_over_limit;
				end else if (bit_pos_q == '0) begin
					res_emit = 1'b1;
					res_kind = EV_DATA;
					res_value = shift_bit;
				end else begin
					res_emit = (dur == '0);
				end
			end
			default: res_emit = 1'b0;
		endcase
	end

	// Counters and byte assembly.
	always_comb begin
		tick_d = tick_q;
		high_d = high_q;
		last_d = last_q;
		bit_pos_d = bit_pos_q;
		shift_d = shift_q;
		bytes_d = bytes_q;
		case (phase_q)
			PH_IDLE: begin
				if (falling) begin
					tick_d = '0;
					high_d = '0;
					last_d = init_sat;
					bit_pos_d = '1;
					shift_d = '0;
					bytes_d = '0;
				end
			end
			PH_SYNC: begin
				tick_d = line_level ? CounterBits'(1) : tick_inc;
			end
			PH_HIGH: begin
				if (!frame_full) begin
					if (line_level) begin
						tick_d = tick_inc;
					end else begin
						high_d = tick_q;
						tick_d = CounterBits'(1);
					end
				end
			end
			default: begin
				if (!line_level) begin
					tick_d = tick_inc;
				end else begin
					last_d = dur;
					tick_d = CounterBits'(1);
					high_d = '0;
					if (bit_pos_q == '0) begin
						shift_d = '0;
						bit_pos_d = '1;
						bytes_d = bytes_q + 1'b1;
					end else begin
						shift_d = shift_bit;
						bit_pos_d = bit_pos_q - 1'b1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_timeout_q <= SYNC_TIMEOUT_RESET;
			initial_fragment_q <= INITIAL_FRAGMENT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_SYNC_TIMEOUT) sync_timeout_q <= cfg_data;
			else initial_fragment_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			prev_level_q <= 1'b1;
			tick_q <= '0;
			high_q <= '0;
			last_q <= '0;
			bit_pos_q <= '1;
			shift_q <= '0;
			bytes_q <= '0;
		end else if (in_accept) begin
			phase_q <= phase_d;
			prev_level_q <= line_level;
			tick_q <= tick_d;
			high_q <= high_d;
			last_q <= last_d;
			bit_pos_q <= bit_pos_d;
			shift_q <= shift_d;
			bytes_q <= bytes_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (in_accept && res_emit) || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && res_emit) begin
			kind_q <= res_kind;
			value_q <= res_value;
			count_q <= res_count;
		end
	end

	assign out_valid = out_valid_q;
	assign event_kind = kind_q;
	assign byte_value = value_q;
	assign byte_count = count_q;

endmodule
